// ===== rtl/core/cse_pkg.sv =====
// Shared types and constants for the cosine similarity engine.
// No dependencies.
`default_nettype none
package cse_pkg;
   localparam int ACC_W = 48;            // running sum width
   localparam int QB    = 16;            // quotient bits
   localparam int PW    = 2 * ACC_W;     // norm product width
   localparam int RW    = 134;           // root search datapath width

   typedef struct packed {
      logic [ACC_W-1:0] dot;
      logic [ACC_W-1:0] norm_a;
      logic [ACC_W-1:0] norm_b;
   } vec_sums_type;

   typedef enum logic [4:0] {
      B_IDLE = 5'b00001,
      B_MUL  = 5'b00010,
      B_PREP = 5'b00100,
      B_ROOT = 5'b01000,
      B_OUT  = 5'b10000
   } back_state_type;
endpackage
`default_nettype wire

// ===== rtl/core/cse_if.sv =====
// Valid/ready channel interfaces for element pairs and similarity results.
// No dependencies.
`default_nettype none
interface cse_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] elem_a;
   logic signed [15:0] elem_b;
   logic               last_elem;
   modport source (output valid, elem_a, elem_b, last_elem, input ready);
   modport sink   (input valid, elem_a, elem_b, last_elem, output ready);
endinterface

interface cse_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] similarity;
   logic               zero_norm;
   modport source (output valid, similarity, zero_norm, input ready);
   modport sink   (input valid, similarity, zero_norm, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cse_front.sv =====
// Front end: accumulates a*b, a*a, b*b per element pair, hands sums off on last.
// Depends on cse_pkg and cse_req_if.
`default_nettype none
module cse_front
   import cse_pkg::*;
#(
   parameter int ELEMENT_BITS = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   cse_req_if.sink     req_chan,
   input  wire logic   push_ready,
   output logic        push_valid,
   output vec_sums_type push_data
);
   localparam int EW = (ELEMENT_BITS < 16) ? ELEMENT_BITS : 16;

   logic [ACC_W-1:0] dot_ff, na_ff, nb_ff;
   logic [ACC_W-1:0] dot_in, na_in, nb_in;
   logic signed [EW-1:0]   a_s, b_s;
   logic signed [2*EW-1:0] ab, aa, bb;
   logic [ACC_W-1:0] dot_sum, na_sum, nb_sum;
   logic take;

   // sign-extend the low element bits and form the three products
   assign a_s = req_chan.elem_a[EW-1:0];
   assign b_s = req_chan.elem_b[EW-1:0];
   assign ab  = a_s * b_s;
   assign aa  = a_s * a_s;
   assign bb  = b_s * b_s;

   assign dot_sum = dot_ff + {{(ACC_W-2*EW){ab[2*EW-1]}}, ab};
   assign na_sum  = na_ff  + {{(ACC_W-2*EW){aa[2*EW-1]}}, aa};
   assign nb_sum  = nb_ff  + {{(ACC_W-2*EW){bb[2*EW-1]}}, bb};

   assign req_chan.ready = push_ready;
   assign take           = req_chan.valid && push_ready;
   assign push_valid     = take && req_chan.last_elem;
   assign push_data      = '{dot: dot_sum, norm_a: na_sum, norm_b: nb_sum};

   // advance sums; clear on the last pair of a vector
   always_comb begin
      dot_in = dot_ff;
      na_in  = na_ff;
      nb_in  = nb_ff;
      if (take) begin
         if (req_chan.last_elem) begin
            dot_in = '0;
            na_in  = '0;
            nb_in  = '0;
         end else begin
            dot_in = dot_sum;
            na_in  = na_sum;
            nb_in  = nb_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff <= '0;
         na_ff  <= '0;
         nb_ff  <= '0;
      end else begin
         dot_ff <= dot_in;
         na_ff  <= na_in;
         nb_ff  <= nb_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/cse_queue.sv =====
// Two-entry queue of finished vector sums between front and back.
// Depends on cse_pkg.
`default_nettype none
module cse_queue
   import cse_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push_valid,
   input  wire vec_sums_type push_data,
   output logic        push_ready,
   input  wire logic   pop,
   output logic        head_valid,
   output vec_sums_type head_data
);
   vec_sums_type slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign head_data  = slot_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = wr_ff ^ do_push;
      rd_in  = rd_ff ^ do_pop;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   // hold payload until overwritten
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/cse_back.sv =====
// Back end: norm product and dot square by shift-add, then bitwise rounded root
// search for dot/sqrt(normA*normB). Depends on cse_pkg and cse_rsp_if.
`default_nettype none
module cse_back
   import cse_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   head_valid,
   input  wire vec_sums_type head_data,
   output logic        pop,
   cse_rsp_if.source   rsp_chan
);
   back_state_type state_ff, state_in;
   logic [5:0]     cnt_ff, cnt_in;
   logic [PW-1:0]  pmc_ff, pmc_in, mmc_ff, mmc_in;
   logic [ACC_W-1:0] pmr_ff, pmr_in, mmr_ff, mmr_in;
   logic [PW-1:0]  pacc_ff, pacc_in, macc_ff, macc_in;
   logic signed [RW-1:0] t_ff, t_in, us_ff, us_in, ps_ff, ps_in, l_ff, l_in;
   logic signed [RW-1:0] trial;
   logic [3:0]     bit_ff, bit_in;
   logic [QB-1:0]  q_ff, q_in;
   logic           neg_ff, neg_in;
   logic signed [15:0] sim_ff, sim_in;
   logic           zn_ff, zn_in;
   logic [ACC_W-1:0] mag;
   logic           fits;

   assign mag   = head_data.dot[ACC_W-1] ? (~head_data.dot + 1'b1) : head_data.dot;
   assign trial = t_ff + us_ff + ps_ff;
   assign fits  = (trial <= l_ff);
   assign pop   = (state_ff == B_IDLE) && head_valid;

   assign rsp_chan.valid      = (state_ff == B_OUT);
   assign rsp_chan.similarity = sim_ff;
   assign rsp_chan.zero_norm  = zn_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      pmc_in = pmc_ff; pmr_in = pmr_ff; pacc_in = pacc_ff;
      mmc_in = mmc_ff; mmr_in = mmr_ff; macc_in = macc_ff;
      t_in = t_ff; us_in = us_ff; ps_in = ps_ff; l_in = l_ff;
      bit_in = bit_ff; q_in = q_ff; neg_in = neg_ff;
      sim_in = sim_ff; zn_in = zn_ff;
      unique case (state_ff)
         B_IDLE: begin
            // take the next vector; zero norms finish at once
            if (head_valid) begin
               neg_in = head_data.dot[ACC_W-1];
               if (head_data.norm_a == '0 || head_data.norm_b == '0) begin
                  sim_in   = '0;
                  zn_in    = 1'b1;
                  state_in = B_OUT;
               end else begin
                  pmc_in  = {{ACC_W{1'b0}}, head_data.norm_a};
                  pmr_in  = head_data.norm_b;
                  pacc_in = '0;
                  mmc_in  = {{ACC_W{1'b0}}, mag};
                  mmr_in  = mag;
                  macc_in = '0;
                  cnt_in  = '0;
                  state_in = B_MUL;
               end
            end
         end
         B_MUL: begin
            // one multiplier bit per cycle for both products
            if (pmr_ff[0]) pacc_in = pacc_ff + pmc_ff;
            if (mmr_ff[0]) macc_in = macc_ff + mmc_ff;
            pmc_in = {pmc_ff[PW-2:0], 1'b0};
            mmc_in = {mmc_ff[PW-2:0], 1'b0};
            pmr_in = {1'b0, pmr_ff[ACC_W-1:1]};
            mmr_in = {1'b0, mmr_ff[ACC_W-1:1]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'(ACC_W - 1)) state_in = B_PREP;
         end
         B_PREP: begin
            // T=(2q-1)^2 P, Us=(2q-1) P 2^(b+2), Ps=P 2^(2b+2) at q=0, b=15
            t_in   = RW'(pacc_ff);
            us_in  = -(RW'(pacc_ff) <<< (QB + 1));
            ps_in  = RW'(pacc_ff) <<< (2 * QB);
            l_in   = RW'(macc_ff) <<< (2 * QB);
            bit_in = 4'(QB - 1);
            q_in   = '0;
            state_in = B_ROOT;
         end
         B_ROOT: begin
            // keep the trial bit while (2q-1)^2 P <= dot^2 2^32
            if (fits) begin
               t_in  = trial;
               q_in  = q_ff | (QB'(1) << bit_ff);
               us_in = (us_ff + (ps_ff <<< 1)) >>> 1;
            end else begin
               us_in = us_ff >>> 1;
            end
            ps_in  = ps_ff >>> 2;
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               zn_in    = 1'b0;
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (rsp_chan.ready) state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
      // saturate and sign the quotient as it completes
      if (state_ff == B_ROOT && bit_ff == '0) begin
         if (neg_ff)
            sim_in = (q_in > 16'd32768) ? 16'sh8000 : 16'(17'd0 - {1'b0, q_in});
         else
            sim_in = (q_in > 16'd32767) ? 16'sh7fff : q_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      pmc_ff <= pmc_in; pmr_ff <= pmr_in; pacc_ff <= pacc_in;
      mmc_ff <= mmc_in; mmr_ff <= mmr_in; macc_ff <= macc_in;
      t_ff <= t_in; us_ff <= us_in; ps_ff <= ps_in; l_ff <= l_in;
      bit_ff <= bit_in; q_ff <= q_in; neg_ff <= neg_in;
      sim_ff <= sim_in; zn_ff <= zn_in;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= B_IDLE;
      else       state_ff <= state_in;
   end
endmodule
`default_nettype wire

// ===== rtl/core/cosine_similarity_engine.sv =====
// Top level of the cosine similarity engine: front, queue and back.
// Depends on cse_pkg, cse_if, cse_front, cse_queue, cse_back.
//
// Usage:
//  req_chan carries one element pair (elem_a, elem_b, signed Q4.12) per
//  transfer; last_elem marks the final pair of a vector pair. rsp_chan
//  carries one result per vector pair: similarity (signed Q1.15, rounded,
//  saturated) and zero_norm (either norm zero, similarity 0).
//  Pairs are taken at one per cycle while req_chan.ready is high. On last
//  the sums move into a two-entry queue; req_chan.ready drops only while
//  that queue is full. With the back end idle, a zero-norm result goes
//  from B_IDLE straight to B_OUT; any other result follows a 48-step
//  shift-add multiply, a setup step and a 16-step root search. The back
//  end works on one vector at a time and goes back to idle only once its
//  result is taken, so short vector pairs are limited by the back end.
//  A result holds on rsp_chan until ready; meanwhile the front keeps
//  accumulating and the queue fills before req_chan stalls.
//  Synchronous reset clears the sums, the queue and any pending result.
`default_nettype none
module cosine_similarity_engine
   import cse_pkg::*;
#(
   parameter int ELEMENT_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   cse_req_if.sink   req_chan,
   cse_rsp_if.source rsp_chan
);
   vec_sums_type push_data, head_data;
   logic push_valid, push_ready, head_valid, pop;

   cse_front #(.ELEMENT_BITS(ELEMENT_BITS)) u_front (
      .clock(clock), .reset(reset), .req_chan(req_chan),
      .push_ready(push_ready), .push_valid(push_valid), .push_data(push_data)
   );

   cse_queue u_queue (
      .clock(clock), .reset(reset),
      .push_valid(push_valid), .push_data(push_data), .push_ready(push_ready),
      .pop(pop), .head_valid(head_valid), .head_data(head_data)
   );

   cse_back u_back (
      .clock(clock), .reset(reset),
      .head_valid(head_valid), .head_data(head_data), .pop(pop),
      .rsp_chan(rsp_chan)
   );
endmodule
`default_nettype wire

// ===== rtl/core/cse_checker.sv =====
// Port-level checks for the cosine similarity engine, bound to the top level.
// Depends on cosine_similarity_engine.
`default_nettype none
module cse_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_last,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_sim,
   input wire logic        rsp_zero
);
   logic [3:0] pend_ff;
   logic       last_take, rsp_take;

   assign last_take = req_valid && req_ready && req_last;
   assign rsp_take  = rsp_valid && rsp_ready;

   // count vectors closed but not yet answered
   always_ff @(posedge clock) begin
      if (reset) pend_ff <= '0;
      else       pend_ff <= pend_ff + {3'd0, last_take} - {3'd0, rsp_take};
   end

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 4'd0) else $error("result without closed vector");

   a_zero_sim: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero |-> rsp_sim == 16'd0) else $error("zero norm with nonzero value");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sim) && $stable(rsp_zero))
      else $error("stalled result changed");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid) else $error("result right after reset");
endmodule

bind cosine_similarity_engine cse_checker u_cse_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_chan.valid), .req_ready(req_chan.ready), .req_last(req_chan.last_elem),
   .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready),
   .rsp_sim(rsp_chan.similarity), .rsp_zero(rsp_chan.zero_norm)
);
`default_nettype wire
